// ===== hdl/lbt_pkg.sv =====
// ----------------------------------------------------------------------------
// lbt_pkg: shared types and constants for the LED breathing/typing effect
// Request codes, mode bits, register indexes, datapath widths and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package lbt_pkg;

  // request kinds
  localparam int REQ_W = 3;
  localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PRESS   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TRESET  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STATIC  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_BREATH  = 3'd5;

  // item field widths
  localparam int PIN_W  = 8;
  localparam int MODE_W = 5;

  // mode encodings
  localparam logic [MODE_W-1:0] MODE_NONE     = 5'd0;
  localparam logic [MODE_W-1:0] MODE_FORCE_ON = 5'd16;
  localparam int MB_HOLD   = 0;
  localparam int MB_EDGE   = 1;
  localparam int MB_BREATH = 2;
  localparam int MB_INVERT = 3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE   = 3'd5;

  // datapath widths
  localparam int PERIOD_W = 16;
  localparam int HALF_W   = PERIOD_W - 1;
  localparam int LVL_W    = 8;
  localparam int MS_W     = 16;
  localparam int PWM_W    = 8;
  localparam int QUO_W    = 17;   // smoothstep argument, 0..65536
  localparam int FAC_W    = 18;   // 3.0 - 2u in Q16
  localparam int SM_W     = 19;   // smoothstep value in Q16
  localparam int FRAC_W   = 16;

  localparam logic [FAC_W-1:0] THREE_Q16 = 18'd196608;

  // register reset values
  localparam logic [PERIOD_W-1:0] RST_PERIOD = 16'd2048;
  localparam logic [LVL_W-1:0]    RST_BASE   = 8'd0;
  localparam logic [LVL_W-1:0]    RST_RANGE  = 8'd255;
  localparam logic [PWM_W-1:0]    RST_STEP   = 8'd16;
  localparam logic [MS_W-1:0]     RST_PULSE  = 16'd50;
  localparam logic [MS_W-1:0]     RST_IDLE   = 16'd1000;

  typedef struct packed {
    logic accept;     // latch the input transfer
    logic exec;       // apply the item's state update
    logic start_mod;  // start divider for the phase wrap
    logic mod_load;   // take remainder as new phase
    logic start_div;  // start divider for the smoothstep argument
    logic mul1;       // u^2 and 3-2u
    logic mul2;       // smoothstep
    logic mul3;       // brightness and pwm compare
    logic finish;     // load the output register
  } lbt_cmd_t;

  typedef struct packed {
    logic breath_work;
    logic need_mod;
    logic div_done;
    logic out_free;
  } lbt_sts_t;

endpackage

// ===== hdl/lbt_div.sv =====
// ----------------------------------------------------------------------------
// lbt_div: radix-2 restoring divider
// Divides {r0, s} by d, one quotient bit per cycle, QUO_W quotient bits.
// Caller keeps r0 < d so the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module lbt_div import lbt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [PERIOD_W-1:0] r0,
  input  logic [QUO_W-1:0]    s,
  input  logic [PERIOD_W-1:0] d,
  output logic                busy,
  output logic                done,
  output logic [QUO_W-1:0]    quot,
  output logic [PERIOD_W-1:0] rem
);

  localparam int CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

  logic [CNT_W-1:0]    cnt;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W-1:0] den;
  logic [QUO_W-1:0]    sh;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   diff;
  logic                ge;

  assign trial = {rem_r, sh[QUO_W-1]};
  assign diff  = trial - {1'b0, den};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= r0;
      sh    <= s;
      den   <= d;
    end else if (busy) begin
      rem_r <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      sh    <= {sh[QUO_W-2:0], ge};
    end
  end

  assign quot = sh;
  assign rem  = rem_r;

endmodule

// ===== hdl/lbt_dp.sv =====
// ----------------------------------------------------------------------------
// lbt_dp: datapath of the LED breathing/typing effect
// Registers, typing timers, breathing phase and PWM counter, smoothstep
// brightness (shared divider plus three multiply steps), output register.
// ----------------------------------------------------------------------------
module lbt_dp import lbt_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [15:0]           s_tdata,
  input  logic [REQ_W-1:0]      s_tuser,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [15:0]           m_tdata,
  input  lbt_cmd_t              cmd,
  output lbt_sts_t              sts
);

  // configuration
  logic [PERIOD_W-1:0] breath_period;
  logic [LVL_W-1:0]    breath_base;
  logic [LVL_W-1:0]    breath_range;
  logic [PWM_W-1:0]    pwm_step;
  logic [MS_W-1:0]     pulse_ms;
  logic [MS_W-1:0]     idle_ms;

  // latched item
  logic [REQ_W-1:0]  req;
  logic [PIN_W-1:0]  pin;
  logic [MODE_W-1:0] mode;
  logic              ind;
  logic              rows;

  // block state
  logic [TIME_BITS-1:0] now_ms;
  logic [TIME_BITS-1:0] last_press_ms;
  logic                 key_held;
  logic [PERIOD_W-1:0]  breath_phase;
  logic [PWM_W-1:0]     pwm_count;

  // result and smoothstep pipeline
  logic             res_drive;
  logic             res_level;
  logic [QUO_W-1:0] u2;
  logic [FAC_W-1:0] fac;
  logic [SM_W-1:0]  sm;

  logic [TIME_BITS-1:0] elapsed;
  logic                 pulse;
  logic                 idle;
  logic [PERIOD_W-1:0]  period_eff;
  logic [HALF_W-1:0]    half;
  logic [PERIOD_W:0]    p1;
  logic [PERIOD_W:0]    p1_sub;
  logic                 p1_lt;
  logic                 p1_sub_lt;
  logic [PERIOD_W-1:0]  mir;
  logic [PERIOD_W-1:0]  mir_c;
  logic                 allow;
  logic [1:0]           static_res;

  logic                div_start;
  logic [PERIOD_W-1:0] div_r0;
  logic [QUO_W-1:0]    div_s;
  logic [PERIOD_W-1:0] div_d;
  logic                div_busy;
  logic                div_done;
  logic [QUO_W-1:0]    div_q;
  logic [PERIOD_W-1:0] div_rem;

  logic [2*QUO_W-1:0]       prod_uu;
  logic [QUO_W+FAC_W-1:0]   prod_sm;
  logic [LVL_W+SM_W-1:0]    prod_b;
  logic [LVL_W+SM_W-FRAC_W-1:0] scaled;
  logic [LVL_W+SM_W-FRAC_W:0]   bsum;
  logic [LVL_W-1:0]         bright;

  function automatic logic [1:0] static_fx(input logic [MODE_W-1:0] m,
                                           input logic kh, input logic pl,
                                           input logic il);
    logic inv, hold, edg, br, act;
    logic [1:0] r;
    inv  = m[MB_INVERT];
    hold = m[MB_HOLD];
    edg  = m[MB_EDGE];
    br   = m[MB_BREATH];
    act  = hold ? kh : pl;
    r    = 2'b00;
    if (m == MODE_FORCE_ON) begin
      r = 2'b11;
    end else if (m == MODE_NONE) begin
      r = 2'b10;
    end else if (br && (hold || edg)) begin
      if (act) begin
        r = {1'b1, !inv};
      end else if (!il) begin
        r = {1'b1, inv};
      end
    end else if (br) begin
      r = 2'b00;
    end else if (hold) begin
      r = {1'b1, kh ? !inv : inv};
    end else if (edg) begin
      r = {1'b1, pl ? !inv : inv};
    end else begin
      r = 2'b10;
    end
    return r;
  endfunction

  // ---- configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      breath_period <= RST_PERIOD;
      breath_base   <= RST_BASE;
      breath_range  <= RST_RANGE;
      pwm_step      <= RST_STEP;
      pulse_ms      <= RST_PULSE;
      idle_ms       <= RST_IDLE;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_PERIOD: breath_period <= cfg_wdata;
        CFG_BASE:   breath_base   <= cfg_wdata[LVL_W-1:0];
        CFG_RANGE:  breath_range  <= cfg_wdata[LVL_W-1:0];
        CFG_STEP:   pwm_step      <= cfg_wdata[PWM_W-1:0];
        CFG_PULSE:  pulse_ms      <= cfg_wdata[MS_W-1:0];
        CFG_IDLE:   idle_ms       <= cfg_wdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- item capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req  <= s_tuser;
      pin  <= s_tdata[PIN_W-1:0];
      mode <= s_tdata[PIN_W +: MODE_W];
      ind  <= s_tdata[PIN_W+MODE_W];
      rows <= s_tdata[PIN_W+MODE_W+1];
    end
  end

  // ---- derived values
  assign elapsed = now_ms - last_press_ms;
  assign pulse   = elapsed < TIME_BITS'(pulse_ms);
  assign idle    = elapsed > TIME_BITS'(idle_ms);

  // low bit cleared, at least two
  assign period_eff = (breath_period[PERIOD_W-1:1] == '0) ? PERIOD_W'(2)
                                                          : {breath_period[PERIOD_W-1:1], 1'b0};
  assign half = period_eff[PERIOD_W-1:1];

  assign p1        = {1'b0, breath_phase} + (PERIOD_W+1)'(1);
  assign p1_sub    = p1 - {1'b0, period_eff};
  assign p1_lt     = p1 < {1'b0, period_eff};
  assign p1_sub_lt = p1_sub < {1'b0, period_eff};

  assign mir   = (breath_phase < {1'b0, half}) ? breath_phase : period_eff - breath_phase;
  assign mir_c = (mir > {1'b0, half}) ? {1'b0, half} : mir;

  assign allow = (!mode[MB_HOLD] && !mode[MB_EDGE]) ? 1'b1 :
                 mode[MB_HOLD] ? (!key_held && idle) : (!pulse && idle);

  assign static_res = static_fx(mode, key_held, pulse, idle);

  assign sts.breath_work = (req == REQ_BREATH) && !ind;
  assign sts.need_mod    = !p1_lt && !p1_sub_lt;
  assign sts.div_done    = div_done;
  assign sts.out_free    = !m_tvalid || m_tready;

  // ---- shared divider: phase wrap, then (mir << 16) / half
  assign div_start = cmd.start_mod || cmd.start_div;
  always_comb begin
    if (cmd.start_mod) begin
      div_r0 = '0;
      div_s  = p1;
      div_d  = period_eff;
    end else begin
      div_r0 = {1'b0, mir_c[PERIOD_W-1:1]};
      div_s  = {mir_c[0], {FRAC_W{1'b0}}};
      div_d  = {1'b0, half};
    end
  end

  lbt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .r0    (div_r0),
    .s     (div_s),
    .d     (div_d),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_q),
    .rem   (div_rem)
  );

  // ---- state update
  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms        <= '0;
      last_press_ms <= '0;
      key_held      <= 1'b0;
      breath_phase  <= '0;
      pwm_count     <= '0;
    end else if (cmd.exec) begin
      case (req)
        REQ_TICK:    now_ms <= now_ms + 1'b1;
        REQ_PRESS: begin
          last_press_ms <= now_ms;
          key_held      <= 1'b1;
        end
        REQ_RELEASE: key_held <= rows;
        REQ_TRESET: begin
          key_held      <= 1'b0;
          last_press_ms <= '0;
        end
        REQ_BREATH: begin
          if (!ind) begin
            pwm_count <= pwm_count + pwm_step;
            if (p1_lt) begin
              breath_phase <= p1[PERIOD_W-1:0];
            end else if (p1_sub_lt) begin
              breath_phase <= p1_sub[PERIOD_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end else if (cmd.mod_load) begin
      breath_phase <= div_rem;
    end
  end

  // ---- smoothstep: u^2, (3 - 2u), product, then scale by range
  assign prod_uu = {{QUO_W{1'b0}}, div_q} * {{QUO_W{1'b0}}, div_q};
  assign prod_sm = {{FAC_W{1'b0}}, u2} * {{QUO_W{1'b0}}, fac};
  assign prod_b  = {{SM_W{1'b0}}, breath_range} * {{LVL_W{1'b0}}, sm};
  assign scaled  = prod_b[LVL_W+SM_W-1:FRAC_W];
  assign bsum    = {1'b0, scaled} + (LVL_W+SM_W-FRAC_W+1)'(breath_base);
  assign bright  = (bsum > (LVL_W+SM_W-FRAC_W+1)'(255)) ? {LVL_W{1'b1}} : bsum[LVL_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      u2  <= prod_uu[QUO_W+FRAC_W-1:FRAC_W];
      fac <= THREE_Q16 - {div_q, 1'b0};
    end
    if (cmd.mul2) begin
      sm <= prod_sm[QUO_W+FAC_W-1:FRAC_W];
    end
  end

  // ---- per-item result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      case (req)
        REQ_STATIC: begin
          res_drive <= static_res[1];
          res_level <= static_res[1] && static_res[0];
        end
        REQ_BREATH: begin
          res_drive <= ind || (mode[MB_BREATH] && allow);
          res_level <= ind;
        end
        default: begin
          res_drive <= 1'b0;
          res_level <= 1'b0;
        end
      endcase
    end else if (cmd.mul3) begin
      res_level <= res_drive && (pwm_count < bright);
    end
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {6'b0, res_level, res_drive, pin};
    end
  end

  // ---- checks
  a_finish_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!m_tvalid || m_tready))
    else $error("output register loaded while still holding a result");

  a_phase_wrapped: assert property (@(posedge clk) disable iff (rst)
    cmd.mul1 |-> (breath_phase < period_eff))
    else $error("breathing phase not wrapped below the period");

  a_level_drive: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!res_level || res_drive))
    else $error("level set on an undriven result");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

// ===== hdl/lbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbt_ctrl: sequencing state machine
// Steps one item through capture, state update, divider passes, the
// smoothstep multiply chain and the output register.
// ----------------------------------------------------------------------------
module lbt_ctrl import lbt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  lbt_sts_t sts,
  output lbt_cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_EXEC = 9'b000000010,
    ST_MOD  = 9'b000000100,
    ST_PREP = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_MUL1 = 9'b000100000,
    ST_MUL2 = 9'b001000000,
    ST_MUL3 = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.accept = s_tvalid;
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (!sts.breath_work) begin
          state_next = ST_OUT;
        end else if (sts.need_mod) begin
          cmd.start_mod = 1'b1;
          state_next    = ST_MOD;
        end else begin
          state_next = ST_PREP;
        end
      end
      ST_MOD: begin
        if (sts.div_done) begin
          cmd.mod_load = 1'b1;
          state_next   = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.start_div = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (sts.div_done) state_next = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/led_breathing_typing_effect.sv =====
// ----------------------------------------------------------------------------
// led_breathing_typing_effect: typing-reactive LED effect with breathing
// Top level: controller state machine plus datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one request per transfer, kind in s_tuser (tick,
//   press, release, typing reset, static pin effect, breathing update).
//   Output stream (m_*): exactly one result per request, in order, saying
//   whether the pin is driven and to which level.
//   Config port: cfg_wen/cfg_addr/cfg_wdata, one register per write, only
//   while no request is in flight. Indexes six and seven are ignored.
// Timing:
//   One request at a time. Non-breathing requests and indicator updates go
//   from capture and state update straight to the output register. A
//   breathing update also waits on the serial divider that forms the
//   smoothstep argument; when the phase plus one reaches twice the period
//   after a period change, one extra divider pass wraps it first.
// Reset: rst (synchronous) restores register defaults, clears the clock,
//   press stamp, key state, phase and PWM counter, and empties the output.
// Stall: a finished result waits in the output register; s_tready comes
//   back as soon as that result is loaded, so the next request can be
//   taken while the previous result is still waiting for m_tready.
// ----------------------------------------------------------------------------
module led_breathing_typing_effect import lbt_pkg::*; #(
  parameter int TIME_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // pin_id[7:0], mode_bits[12:8],
                                           // ind_active[13], rows_active[14]
  input  logic [REQ_W-1:0]      s_tuser,   // req_type[2:0]
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // out_pin[7:0], drive[8], level[9]
  // configuration
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  lbt_cmd_t cmd;
  lbt_sts_t sts;

  // sequencing: one request stepped through its stages
  lbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // registers, timers, breathing math and output register
  lbt_dp #(
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== sim/tb_led_breathing_typing_effect.sv =====
// ----------------------------------------------------------------------------
// tb_led_breathing_typing_effect: self-checking bench for the LED effect block
// Drives request streams (ticks, presses, releases, typing resets, static pin
// requests, breathing updates) with bursty timing, predicts every pin write in
// a behavioral model of its own, and compares results in order while the
// output side stalls on its own pattern. Register settings change between
// phases, covering extremes, odd and tiny periods, and period shrinks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_led_breathing_typing_effect;
  import lbt_pkg::*;

  // request codes the block decodes as no-ops
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

  // single mode bits and the all-ones pattern
  localparam logic [MODE_W-1:0] M_HOLD   = 5'd1 << MB_HOLD;
  localparam logic [MODE_W-1:0] M_EDGE   = 5'd1 << MB_EDGE;
  localparam logic [MODE_W-1:0] M_BREATH = 5'd1 << MB_BREATH;
  localparam logic [MODE_W-1:0] M_INV    = 5'd1 << MB_INVERT;
  localparam logic [MODE_W-1:0] M_ALL    = 5'h1F;

  localparam int DRAIN_CYCLES = 60;       // > longest breathing update, in cycles
  localparam int LONG_HOLD    = 400;      // receiver hold-off, in cycles

  // one input transfer, unpacked
  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [PIN_W-1:0]  pin;
    logic [MODE_W-1:0] mode;
    logic              ind;
    logic              rows;
  } led_req_t;

  // one result: which pin, driven or not, and the level
  typedef struct packed {
    logic [PIN_W-1:0] pin;
    logic             drive;
    logic             level;
  } pin_write_t;

  // --------------------------------------------------------------------------
  // clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata   = '0;    // pin_id[7:0], mode_bits[12:8],
                                            // ind_active[13], rows_active[14]
  logic [REQ_W-1:0]      s_tuser   = '0;    // req_type[2:0]
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [15:0]           m_tdata;           // out_pin[7:0], drive[8], level[9]
  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  led_breathing_typing_effect dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // behavioral model: register copies and effect state
  // --------------------------------------------------------------------------
  logic [PERIOD_W-1:0] r_period = RST_PERIOD;
  logic [LVL_W-1:0]    r_base   = RST_BASE;
  logic [LVL_W-1:0]    r_range  = RST_RANGE;
  logic [PWM_W-1:0]    r_step   = RST_STEP;
  logic [MS_W-1:0]     r_pulse  = RST_PULSE;
  logic [MS_W-1:0]     r_idle   = RST_IDLE;

  logic [31:0]         ms_now      = '0;
  logic [31:0]         press_stamp = '0;
  logic                key_down    = 1'b0;
  logic [PERIOD_W-1:0] phase_acc   = '0;
  logic [PWM_W-1:0]    pwm_acc     = '0;

  led_req_t   request_q[$];     // items waiting for the driver
  pin_write_t pin_writes_q[$];  // predicted results, oldest first

  int mismatches     = 0;
  int counted_items  = 0;       // items that the block does not ignore

  // Smoothstep brightness over the mirrored phase. Wide math so the peak
  // (u = 1.0) gives base + range exactly; the sum then clips at full scale.
  function automatic logic [LVL_W-1:0] smooth_level(input logic [PERIOD_W-1:0] ph,
                                                    input logic [PERIOD_W-1:0] per);
    logic [63:0] half, mir, u, u2, sm, b;
    half = {48'd0, per} >> 1;
    mir  = ({48'd0, ph} < half) ? {48'd0, ph} : {48'd0, per} - {48'd0, ph};
    if (mir > half)
      mir = half;
    u  = (mir << 16) / half;
    u2 = (u * u) >> 16;
    sm = (u2 * ((64'd3 << 16) - (u << 1))) >> 16;
    b  = {56'd0, r_base} + (({56'd0, r_range} * sm) >> 16);
    return (b > 64'd255) ? 8'hFF : b[7:0];
  endfunction

  // Advance the model by one request and return the pin write it causes.
  function automatic pin_write_t led_effect_next(input led_req_t r);
    pin_write_t          o;
    logic [31:0]         el;
    logic                pulse, idle, inv, hold, edg, brth, active, allow;
    logic [PERIOD_W-1:0] per;
    logic [LVL_W-1:0]    bright;
    o.pin   = r.pin;
    o.drive = 1'b0;
    o.level = 1'b0;
    inv   = r.mode[MB_INVERT];
    hold  = r.mode[MB_HOLD];
    edg   = r.mode[MB_EDGE];
    brth  = r.mode[MB_BREATH];
    el    = ms_now - press_stamp;          // modulo 2^32
    pulse = el < {16'd0, r_pulse};
    idle  = el > {16'd0, r_idle};
    allow = 1'b0;
    case (r.req)
      REQ_TICK:    ms_now = ms_now + 32'd1;
      REQ_PRESS: begin
        press_stamp = ms_now;
        key_down    = 1'b1;
      end
      REQ_RELEASE: key_down = r.rows;
      REQ_TRESET: begin
        key_down    = 1'b0;
        press_stamp = '0;
      end
      REQ_STATIC: begin
        if (r.mode == MODE_FORCE_ON) begin
          o.drive = 1'b1;
          o.level = 1'b1;
        end else if (r.mode == MODE_NONE) begin
          o.drive = 1'b1;
        end else if (brth && (hold || edg)) begin
          // breathing pins follow typing while active, idle level until idle
          active = hold ? key_down : pulse;
          if (active) begin
            o.drive = 1'b1;
            o.level = !inv;
          end else if (!idle) begin
            o.drive = 1'b1;
            o.level = inv;
          end
        end else if (brth) begin
          o.drive = 1'b0;                  // left to the breathing updates
        end else if (hold) begin
          o.drive = 1'b1;
          o.level = key_down ? !inv : inv;
        end else if (edg) begin
          o.drive = 1'b1;
          o.level = pulse ? !inv : inv;
        end else begin
          o.drive = 1'b1;                  // invert alone: low
        end
      end
      REQ_BREATH: begin
        if (r.ind) begin
          o.drive = 1'b1;
          o.level = 1'b1;
        end else begin
          // even period, at least two; stale phase wraps by the modulo
          per = {r_period[PERIOD_W-1:1], 1'b0};
          if (per < 16'd2)
            per = 16'd2;
          phase_acc = 16'(({16'd0, phase_acc} + 32'd1) % {16'd0, per});
          bright    = smooth_level(phase_acc, per);
          pwm_acc   = pwm_acc + r_step;
          if (brth) begin
            if (!hold && !edg)
              allow = 1'b1;
            else if (hold)
              allow = !key_down && idle;
            else
              allow = !pulse && idle;
            if (allow) begin
              o.drive = 1'b1;
              o.level = pwm_acc < bright;
            end
          end
        end
      end
      default: ;                           // spare codes change nothing
    endcase
    o.level = o.drive && o.level;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // failure log: first ten in full, the rest only counted
  // --------------------------------------------------------------------------
  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10)
      $display("%t mismatch: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // input driver: bursts of random length with random gaps between them
  // --------------------------------------------------------------------------
  logic     took_in         = 1'b0;   // a transfer happened at the last rising edge
  logic     sender_offering = 1'b0;   // s_tvalid as seen at the last rising edge
  int       burst_left      = 0;
  int       gap_left        = 0;
  led_req_t nxt;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || took_in) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (request_q.size() != 0) begin
        nxt = request_q.pop_front();
        s_tdata  <= {1'b0, nxt.rows, nxt.ind, nxt.mode, nxt.pin};
        s_tuser  <= nxt.req;
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          // a third of the bursts run back to back
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall styles that change every stretch, plus long hold-offs
  // --------------------------------------------------------------------------
  int rx_cycles  = 0;
  int style      = 0;
  int style_left = 0;
  int hold_left  = 0;
  int holds_done = 0;
  int hold_at    = 2500;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else if (holds_done < 2 && rx_cycles > hold_at && sender_offering && m_tvalid) begin
        // a result is waiting and the sender keeps offering: sit on it so the
        // block fills up and drops s_tready
        hold_left  <= LONG_HOLD;
        holds_done <= holds_done + 1;
        hold_at    <= rx_cycles + 8000;
        m_tready   <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      <= $urandom_range(0, 3);
          style_left <= $urandom_range(20, 200);
        end else begin
          style_left <= style_left - 1;
        end
        case (style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitors: predict on input transfers, check on output transfers
  // --------------------------------------------------------------------------
  led_req_t   seen_req;
  pin_write_t want;

  always @(posedge clk) begin
    took_in         <= !rst && s_tvalid && s_tready;
    sender_offering <= s_tvalid;
    if (!rst && s_tvalid && s_tready) begin
      seen_req.req  = s_tuser;
      seen_req.pin  = s_tdata[7:0];
      seen_req.mode = s_tdata[12:8];
      seen_req.ind  = s_tdata[13];
      seen_req.rows = s_tdata[14];
      pin_writes_q.push_back(led_effect_next(seen_req));
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pin_writes_q.size() == 0) begin
        log_mismatch($sformatf("result with nothing outstanding, tdata=%h", m_tdata));
      end else begin
        want = pin_writes_q.pop_front();
        if (m_tdata[7:0] !== want.pin || m_tdata[8] !== want.drive ||
            m_tdata[9] !== want.level)
          log_mismatch($sformatf("pin exp %h got %h, drive exp %b got %b, level exp %b got %b",
                                 want.pin, m_tdata[7:0], want.drive, m_tdata[8],
                                 want.level, m_tdata[9]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_req(input logic [REQ_W-1:0] req, input logic [PIN_W-1:0] pin,
                           input logic [MODE_W-1:0] mode, input logic ind,
                           input logic rows);
    led_req_t r;
    r = '{req: req, pin: pin, mode: mode, ind: ind, rows: rows};
    request_q.push_back(r);
    if (req <= REQ_BREATH)
      counted_items++;
  endtask

  // random fields around a given kind; modes lean toward the breathing
  // combinations and the two fixed codes
  function automatic led_req_t rand_item(input logic [REQ_W-1:0] kind);
    led_req_t r;
    r.req  = kind;
    r.pin  = PIN_W'($urandom_range(0, 255));
    r.rows = 1'($urandom_range(0, 1));
    r.ind  = (kind == REQ_BREATH) ? ($urandom_range(0, 6) == 0) : 1'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0:       r.mode = ($urandom_range(0, 1) != 0) ? MODE_FORCE_ON : MODE_NONE;
      1, 2:    r.mode = M_BREATH | (($urandom_range(0, 1) != 0) ? M_HOLD : MODE_NONE)
                                 | (($urandom_range(0, 1) != 0) ? M_EDGE : MODE_NONE)
                                 | (($urandom_range(0, 1) != 0) ? M_INV  : MODE_NONE);
      default: r.mode = MODE_W'($urandom_range(0, 31));
    endcase
    return r;
  endfunction

  task automatic queue_rand(input logic [REQ_W-1:0] kind);
    led_req_t r;
    r = rand_item(kind);
    queue_req(r.req, r.pin, r.mode, r.ind, r.rows);
  endtask

  // time passing with breathing and static traffic, a little noise mixed in
  task automatic queue_activity(input int len);
    int k, pick;
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      queue_rand(REQ_TICK);
      else if (pick < 75) queue_rand(REQ_BREATH);
      else if (pick < 95) queue_rand(REQ_STATIC);
      else                queue_rand(REQ_W'($urandom_range(0, 7)));
    end
  endtask

  // wait until every request went in and every result came out
  task automatic wait_idle();
    while (request_q.size() != 0 || s_tvalid || pin_writes_q.size() != 0)
      @(posedge clk);
  endtask

  // one register write; the model copy follows the same mask
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PERIOD: r_period = val;
      CFG_BASE:   r_base   = val[LVL_W-1:0];
      CFG_RANGE:  r_range  = val[LVL_W-1:0];
      CFG_STEP:   r_step   = val[PWM_W-1:0];
      CFG_PULSE:  r_pulse  = val;
      CFG_IDLE:   r_idle   = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic set_regs(input int per, input int base, input int rng, input int step,
                          input int pls, input int idl);
    write_reg(CFG_PERIOD, per[15:0]);
    write_reg(CFG_BASE,   base[15:0]);
    write_reg(CFG_RANGE,  rng[15:0]);
    write_reg(CFG_STEP,   step[15:0]);
    write_reg(CFG_PULSE,  pls[15:0]);
    write_reg(CFG_IDLE,   idl[15:0]);
  endtask

  // typing episodes: press, activity, release (rows random), more activity;
  // one in ten is loose noise instead
  task automatic run_phase(input int n);
    int goal;
    goal = counted_items + n;
    while (counted_items < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_rand(REQ_W'($urandom_range(0, 7)));
      end else begin
        queue_rand(REQ_PRESS);
        queue_activity($urandom_range(2, 30));
        queue_rand(REQ_RELEASE);
        queue_activity($urandom_range(0, 30));
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every request kind, every mode class, extreme field values
    queue_req(REQ_TICK,    8'h00, MODE_NONE,         1'b0, 1'b0);
    queue_req(REQ_PRESS,   8'hFF, M_ALL,             1'b1, 1'b1);
    queue_req(REQ_STATIC,  8'h5A, M_HOLD,            1'b0, 1'b0);  // key held: high
    queue_req(REQ_STATIC,  8'hA5, M_HOLD | M_INV,    1'b1, 1'b1);
    queue_req(REQ_RELEASE, 8'h01, MODE_NONE,         1'b0, 1'b1);  // other key still down
    queue_req(REQ_RELEASE, 8'h02, M_ALL,             1'b1, 1'b0);
    queue_req(REQ_STATIC,  8'h03, M_EDGE,            1'b0, 1'b0);  // inside the pulse
    queue_req(REQ_STATIC,  8'h04, M_EDGE | M_INV,    1'b0, 1'b0);
    queue_req(REQ_STATIC,  8'h00, MODE_NONE,         1'b0, 1'b0);
    queue_req(REQ_STATIC,  8'hFF, MODE_FORCE_ON,     1'b1, 1'b1);
    queue_req(REQ_STATIC,  8'h10, M_INV,             1'b0, 1'b0);  // invert alone: low
    queue_req(REQ_STATIC,  8'h20, M_BREATH,          1'b0, 1'b0);  // not driven
    queue_req(REQ_STATIC,  8'h30, M_BREATH | M_HOLD, 1'b0, 1'b0);
    queue_req(REQ_STATIC,  8'h40, M_BREATH | M_EDGE | M_INV, 1'b0, 1'b0);
    queue_req(REQ_STATIC,  8'h50, M_ALL,             1'b1, 1'b1);
    queue_req(REQ_BREATH,  8'h60, M_ALL,             1'b1, 1'b1);  // indicator on
    queue_req(REQ_BREATH,  8'h70, M_BREATH,          1'b0, 1'b0);
    queue_req(REQ_BREATH,  8'h80, M_BREATH | M_HOLD, 1'b0, 1'b1);
    queue_req(REQ_BREATH,  8'h90, M_BREATH | M_EDGE, 1'b0, 1'b0);
    queue_req(REQ_BREATH,  8'hA0, MODE_NONE,         1'b0, 1'b0);  // no breathing bit
    queue_req(REQ_TRESET,  8'hB0, M_ALL,             1'b1, 1'b1);
    queue_req(REQ_SPARE_A, 8'hFF, M_ALL,             1'b1, 1'b1);
    queue_req(REQ_SPARE_B, 8'h00, MODE_NONE,         1'b0, 1'b0);
    wait_idle();

    // odd period (rounds down to two): every other update lands on the peak,
    // and base plus range overflows the brightness
    set_regs(3, 255, 255, 255, 0, 0);
    write_reg(CFG_SPARE, 16'hFFFF);
    repeat (3) queue_req(REQ_BREATH, 8'hC0, M_BREATH, 1'b0, 1'b0);
    wait_idle();

    // period below two clamps to two
    write_reg(CFG_PERIOD, 16'd1);
    write_reg(CFG_BASE,   16'd200);
    write_reg(CFG_RANGE,  16'd100);
    repeat (2) queue_req(REQ_BREATH, 8'hC1, M_BREATH, 1'b0, 1'b0);
    wait_idle();

    // walk the phase up, then shrink the period below it
    write_reg(CFG_PERIOD, 16'd8);
    write_reg(CFG_BASE,   16'd0);
    write_reg(CFG_STEP,   16'd37);
    repeat (7) queue_req(REQ_BREATH, 8'hC2, M_BREATH, 1'b0, 1'b0);
    wait_idle();
    write_reg(CFG_PERIOD, 16'd2);
    repeat (2) queue_req(REQ_BREATH, 8'hC3, M_BREATH, 1'b0, 1'b0);
    wait_idle();

    // random phases, each under its own settings
    set_regs(int'(RST_PERIOD), int'(RST_BASE), int'(RST_RANGE), int'(RST_STEP),
             int'(RST_PULSE), int'(RST_IDLE));
    run_phase(105);
    set_regs(16, 20, 200, 16, 3, 10);
    run_phase(105);
    set_regs(65534, 255, 255, 255, 65535, 65535);
    run_phase(105);
    set_regs(2, 0, 0, 0, 0, 0);                // long-period phase left far behind
    run_phase(105);
    set_regs($urandom_range(2, 40) | 1, $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 8), $urandom_range(0, 25));
    run_phase(105);
    set_regs($urandom_range(0, 80), $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255), $urandom_range(0, 12), $urandom_range(0, 40));
    run_phase(105);

    // let anything stray come out before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pin_writes_q.size() != 0)
      $display("%0d expected results never arrived", pin_writes_q.size());
    if (mismatches == 0 && pin_writes_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/lbt_pkg.sv
hdl/lbt_div.sv
hdl/lbt_dp.sv
hdl/lbt_ctrl.sv
hdl/led_breathing_typing_effect.sv
sim/tb_led_breathing_typing_effect.sv
